### rtl/prse_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// prse_pkg: shared types and constants of the pulse rate and SpO2 estimator
// Beat payloads, configuration set, queue entry and back-end states.
// -----------------------------------------------------------------------------
package prse_pkg;

   localparam int FIELD_W    = 18;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int RATE_W     = 8;
   localparam int SPO2_W     = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_SEL_W  = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_SEL_W-1:0] CSR_ENABLE       = 3'd0;
   localparam logic [CSR_SEL_W-1:0] CSR_IR_THRESHOLD = 3'd1;
   localparam logic [CSR_SEL_W-1:0] CSR_MIN_INTERVAL = 3'd2;
   localparam logic [CSR_SEL_W-1:0] CSR_MAX_INTERVAL = 3'd3;
   localparam logic [CSR_SEL_W-1:0] CSR_SIGNAL_FLOOR = 3'd4;

   localparam logic [FIELD_W-1:0]    RST_IR_THRESHOLD = 18'd50000;
   localparam logic [INTERVAL_W-1:0] RST_MIN_INTERVAL = 16'd300;
   localparam logic [INTERVAL_W-1:0] RST_MAX_INTERVAL = 16'd3000;
   localparam logic [FIELD_W-1:0]    RST_SIGNAL_FLOOR = 18'd1000;

   localparam logic [INTERVAL_W-1:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [SPO2_W-1:0]     SPO2_OFFSET   = 7'd110;
   localparam logic [4:0]            SPO2_SLOPE    = 5'd25;
   localparam logic [SPO2_W-1:0]     SPO2_MIN      = 7'd70;
   localparam logic [SPO2_W-1:0]     SPO2_MAX      = 7'd100;
   localparam logic [SPO2_W-1:0]     SPO2_Q_LOW    = SPO2_OFFSET - SPO2_MIN;
   localparam logic [SPO2_W-1:0]     SPO2_Q_HIGH   = SPO2_OFFSET - SPO2_MAX;

   typedef struct packed {
      logic [FIELD_W-1:0] ir_sample;
      logic [FIELD_W-1:0] red_sample;
      logic [TIME_W-1:0]  time_ms;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0] heart_rate_bpm;
      logic [SPO2_W-1:0] spo2_percent;
      logic              beat_accepted;
   } rsp_type;

   typedef struct packed {
      logic                  enable;
      logic [FIELD_W-1:0]    ir_presence_threshold;
      logic [INTERVAL_W-1:0] min_interval_ms;
      logic [INTERVAL_W-1:0] max_interval_ms;
      logic [FIELD_W-1:0]    signal_floor;
   } cfg_type;

   typedef struct packed {
      logic                  accepted;
      logic                  spo2_update;
      logic [INTERVAL_W-1:0] gap;
      logic [FIELD_W-1:0]    ir_sample;
      logic [FIELD_W-1:0]    red_sample;
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_RATE,
      BACK_SPO2
   } back_state_type;

endpackage
`default_nettype wire

### rtl/prse_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// prse_div: restoring unsigned divider
// One quotient bit per cycle; done pulses when quot holds the result.
// -----------------------------------------------------------------------------
module prse_div #(
   parameter int NUM_W = 23,
   parameter int DEN_W = 18
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             ge;

   assign rem_sh  = {rem_ff, num_ff[NUM_W-1]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule
`default_nettype wire

### rtl/prse_queue.sv
`default_nettype none
// -----------------------------------------------------------------------------
// prse_queue: short command queue between front and back end
// Register-based FIFO of classified samples.
// -----------------------------------------------------------------------------
module prse_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire prse_pkg::cmd_type data_in,
   output logic                   full,
   input  wire logic              pop,
   output prse_pkg::cmd_type      data_out,
   output logic                   empty
);

   localparam int DEPTH = prse_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   prse_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= data_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule
`default_nettype wire

### rtl/prse_front.sv
`default_nettype none
// -----------------------------------------------------------------------------
// prse_front: sample classifier
// Checks presence and beat interval, keeps the last beat time, queues a command.
// -----------------------------------------------------------------------------
module prse_front #(
   parameter int SAMPLE_W = 18
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire prse_pkg::cfg_type cfg,
   input  wire logic              push,
   input  wire prse_pkg::req_type req_item,
   output logic                   full,
   output logic                   q_push,
   output prse_pkg::cmd_type      q_cmd,
   input  wire logic              q_full
);

   localparam int FW = prse_pkg::FIELD_W;
   localparam int TW = prse_pkg::TIME_W;
   localparam logic [FW-1:0] SMASK = {FW{1'b1}} >> (FW - SAMPLE_W);

   logic [TW-1:0] last_beat_ff, last_beat_in;
   logic [FW-1:0] ir;
   logic [FW-1:0] red;
   logic [TW-1:0] gap;
   logic          accept;
   logic          present;
   logic          in_window;
   logic          rearm;

   assign accept    = push && !q_full;
   assign ir        = req_item.ir_sample & SMASK;
   assign red       = req_item.red_sample & SMASK;
   assign present   = cfg.enable && (ir > cfg.ir_presence_threshold);
   assign gap       = req_item.time_ms - last_beat_ff;
   assign in_window = (gap > TW'(cfg.min_interval_ms)) && (gap < TW'(cfg.max_interval_ms));
   assign rearm     = gap >= TW'(cfg.max_interval_ms);

   always_comb begin
      last_beat_in = last_beat_ff;
      if (accept && present && (in_window || rearm)) begin
         last_beat_in = req_item.time_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_beat_ff <= '0;
      end else begin
         last_beat_ff <= last_beat_in;
      end
   end

   assign full   = q_full;
   assign q_push = accept;

   always_comb begin
      q_cmd.accepted    = present && in_window;
      q_cmd.spo2_update = present && in_window && (red > cfg.signal_floor)
                          && (ir > cfg.signal_floor);
      q_cmd.gap         = gap[prse_pkg::INTERVAL_W-1:0];
      q_cmd.ir_sample   = ir;
      q_cmd.red_sample  = red;
   end

endmodule
`default_nettype wire

### rtl/prse_back.sv
`default_nettype none
// -----------------------------------------------------------------------------
// prse_back: rate and SpO2 evaluation
// Runs the shared divider for 60000/interval and ceil(25*red/ir), holds results.
// -----------------------------------------------------------------------------
module prse_back #(
   parameter int SAMPLE_W = 18
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   output logic                   q_pop,
   input  wire prse_pkg::cmd_type q_cmd,
   output logic                   empty,
   input  wire logic              pop,
   output prse_pkg::rsp_type      rsp_item
);

   localparam int NUM_W = SAMPLE_W + 5;
   localparam int DEN_W = SAMPLE_W;
   localparam int RW    = prse_pkg::RATE_W;
   localparam int SW    = prse_pkg::SPO2_W;

   prse_pkg::back_state_type state_ff, state_in;
   prse_pkg::cmd_type        cmd_ff, cmd_in;
   prse_pkg::rsp_type        out_data_ff, out_data_in;
   logic [RW-1:0]            rate_ff, rate_in;
   logic [SW-1:0]            sat_ff, sat_in;
   logic                     out_valid_ff, out_valid_in;

   logic             div_start;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic             div_done;
   logic [NUM_W-1:0] div_quot;
   logic [NUM_W-1:0] spo2_num;
   logic [SW-1:0]    spo2_val;

   prse_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ceil(25*red/ir) as floor((25*red + ir - 1)/ir)
   assign spo2_num = NUM_W'(cmd_ff.red_sample[SAMPLE_W-1:0]) * NUM_W'(prse_pkg::SPO2_SLOPE)
                     + NUM_W'(cmd_ff.ir_sample[SAMPLE_W-1:0]) - NUM_W'(1);

   always_comb begin
      if (div_quot >= NUM_W'(prse_pkg::SPO2_Q_LOW)) begin
         spo2_val = prse_pkg::SPO2_MIN;
      end else if (div_quot <= NUM_W'(prse_pkg::SPO2_Q_HIGH)) begin
         spo2_val = prse_pkg::SPO2_MAX;
      end else begin
         spo2_val = prse_pkg::SPO2_OFFSET - div_quot[SW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rate_in      = rate_ff;
      sat_in       = sat_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         prse_pkg::BACK_IDLE: begin
            if (!q_empty && !out_valid_ff) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.accepted) begin
                  div_start = 1'b1;
                  div_num   = NUM_W'(prse_pkg::MS_PER_MINUTE);
                  div_den   = DEN_W'(q_cmd.gap);
                  state_in  = prse_pkg::BACK_RATE;
               end else begin
                  out_valid_in = 1'b1;
                  out_data_in  = '{heart_rate_bpm: rate_ff, spo2_percent: sat_ff,
                                   beat_accepted: 1'b0};
               end
            end
         end
         prse_pkg::BACK_RATE: begin
            if (div_done) begin
               if (div_quot[NUM_W-1:RW] == '0) begin
                  rate_in = div_quot[RW-1:0];
               end
               if (cmd_ff.spo2_update) begin
                  div_start = 1'b1;
                  div_num   = spo2_num;
                  div_den   = cmd_ff.ir_sample[DEN_W-1:0];
                  state_in  = prse_pkg::BACK_SPO2;
               end else begin
                  out_valid_in = 1'b1;
                  out_data_in  = '{heart_rate_bpm: rate_in, spo2_percent: sat_ff,
                                   beat_accepted: 1'b1};
                  state_in     = prse_pkg::BACK_IDLE;
               end
            end
         end
         prse_pkg::BACK_SPO2: begin
            if (div_done) begin
               sat_in       = spo2_val;
               out_valid_in = 1'b1;
               out_data_in  = '{heart_rate_bpm: rate_ff, spo2_percent: spo2_val,
                                beat_accepted: 1'b1};
               state_in     = prse_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = prse_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prse_pkg::BACK_IDLE;
         rate_ff      <= '0;
         sat_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      out_data_ff <= out_data_in;
   end

   assign empty    = !out_valid_ff;
   assign rsp_item = out_data_ff;

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      sat_ff == '0 || (sat_ff >= prse_pkg::SPO2_MIN && sat_ff <= prse_pkg::SPO2_MAX))
      else $error("SpO2 outside clamp range");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff != prse_pkg::BACK_IDLE)
      else $error("divider result with no evaluation pending");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !pop |=> out_valid_ff && $stable(out_data_ff))
      else $error("waiting result overwritten");

endmodule
`default_nettype wire

### rtl/pulse_rate_and_spo2_estimator.sv
`default_nettype none
// -----------------------------------------------------------------------------
// pulse_rate_and_spo2_estimator: beat detection, heart rate and SpO2 estimate
// Sample pairs enter a classifier and a two-entry queue; a back end computes
// the rate and saturation with one shared divider. Registers on an APB port.
// -----------------------------------------------------------------------------
// A sample that is not taken as a beat goes through the queue to the result
// ports once the output is free. A beat runs the shared restoring divider,
// one quotient bit per cycle over SAMPLE_BITS+5 bits (SAMPLE_BITS capped at
// 18; 23 at the default width): one division gives the rate, and a second
// one follows for SpO2 when SpO2 is updated too. The back end takes the next
// sample only once the output is free again after the pop, so while a result
// waits the front end fills the two-entry queue and then holds full high.
module pulse_rate_and_spo2_estimator #(
   parameter int SAMPLE_BITS = 18
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire prse_pkg::req_type                   req_item,
   output logic                                     empty,
   input  wire logic                                pop,
   output prse_pkg::rsp_type                        rsp_item,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [prse_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [prse_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [prse_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                     pready
);

   localparam int SAMPLE_W = (SAMPLE_BITS < prse_pkg::FIELD_W) ? SAMPLE_BITS
                                                               : prse_pkg::FIELD_W;
   localparam int DW = prse_pkg::CSR_DATA_W;

   prse_pkg::cfg_type cfg_ff, cfg_in;
   prse_pkg::cmd_type q_in_cmd;
   prse_pkg::cmd_type q_out_cmd;
   logic [prse_pkg::CSR_SEL_W-1:0] csr_sel;
   logic csr_write;
   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_empty;

   assign pready    = 1'b1;
   assign csr_sel   = paddr[prse_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_sel)
            prse_pkg::CSR_ENABLE:       cfg_in.enable = pwdata[0];
            prse_pkg::CSR_IR_THRESHOLD: begin
               cfg_in.ir_presence_threshold = pwdata[prse_pkg::FIELD_W-1:0];
            end
            prse_pkg::CSR_MIN_INTERVAL: begin
               cfg_in.min_interval_ms = pwdata[prse_pkg::INTERVAL_W-1:0];
            end
            prse_pkg::CSR_MAX_INTERVAL: begin
               cfg_in.max_interval_ms = pwdata[prse_pkg::INTERVAL_W-1:0];
            end
            prse_pkg::CSR_SIGNAL_FLOOR: begin
               cfg_in.signal_floor = pwdata[prse_pkg::FIELD_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         prse_pkg::CSR_ENABLE:       prdata = DW'(cfg_ff.enable);
         prse_pkg::CSR_IR_THRESHOLD: prdata = DW'(cfg_ff.ir_presence_threshold);
         prse_pkg::CSR_MIN_INTERVAL: prdata = DW'(cfg_ff.min_interval_ms);
         prse_pkg::CSR_MAX_INTERVAL: prdata = DW'(cfg_ff.max_interval_ms);
         prse_pkg::CSR_SIGNAL_FLOOR: prdata = DW'(cfg_ff.signal_floor);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable                <= 1'b1;
         cfg_ff.ir_presence_threshold <= prse_pkg::RST_IR_THRESHOLD;
         cfg_ff.min_interval_ms       <= prse_pkg::RST_MIN_INTERVAL;
         cfg_ff.max_interval_ms       <= prse_pkg::RST_MAX_INTERVAL;
         cfg_ff.signal_floor          <= prse_pkg::RST_SIGNAL_FLOOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   prse_front #(
      .SAMPLE_W (SAMPLE_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .req_item (req_item),
      .full     (full),
      .q_push   (q_push),
      .q_cmd    (q_in_cmd),
      .q_full   (q_full)
   );

   prse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_in_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .data_out (q_out_cmd),
      .empty    (q_empty)
   );

   prse_back #(
      .SAMPLE_W (SAMPLE_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_cmd    (q_out_cmd),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top: self-checking bench for the pulse rate and SpO2 estimator
// Drives optical sample beats through the push/full queue port and programs
// the register set over APB. A local estimator model works out each expected
// rate/SpO2 reading; every popped result beat is compared field by field.
// A short directed table is followed by random phases with varied settings,
// sender gaps, receiver stalls, a long receiver hold-off and a full drain.
// -----------------------------------------------------------------------------
module tb_top;

   localparam int FW    = prse_pkg::FIELD_W;
   localparam int TW    = prse_pkg::TIME_W;
   localparam int IW    = prse_pkg::INTERVAL_W;
   localparam int RW    = prse_pkg::RATE_W;
   localparam int SW    = prse_pkg::SPO2_W;
   localparam int DW    = prse_pkg::CSR_DATA_W;
   localparam int AW    = prse_pkg::CSR_ADDR_W;
   localparam int SEL_W = prse_pkg::CSR_SEL_W;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 220;
   localparam logic [FW-1:0] SAMPLE_TOP = '1;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [SEL_W-1:0]       sel;
      logic [DW-1:0]          wdata;
      prse_pkg::req_type      sample;
      bit                     known;
      prse_pkg::rsp_type      golden;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   prse_pkg::req_type     req_item = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   prse_pkg::rsp_type     rsp_item;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [AW-1:0]         paddr = '0;
   logic [DW-1:0]         pwdata = '0;
   logic [DW-1:0]         prdata;
   logic                  pready;

   // estimator mirror
   prse_pkg::cfg_type     cfg;
   logic [TW-1:0]         beat_time;
   logic [RW-1:0]         rate_bpm;
   logic [SW-1:0]         spo2_pct;

   prse_pkg::rsp_type     readings_due[$];
   prse_pkg::rsp_type     oldest_due;
   plan_row_type          plan[$];
   logic [TW-1:0]         sample_clock = '0;
   int                    send_idle_pct = 0;
   int                    stall_pct = 0;
   int                    hold_requests = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;
   int                    fail_count = 0;
   int                    cycle_count = 0;

   pulse_rate_and_spo2_estimator u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** pulse_rate_and_spo2_estimator: FAILED **");
         $finish;
      end
   end

   function automatic prse_pkg::rsp_type estimate_reading(input prse_pkg::req_type s);
      logic [TW-1:0]     gap;
      logic [31:0]       hr;
      logic [63:0]       num;
      logic [63:0]       q;
      prse_pkg::rsp_type r;
      r = '0;
      if (cfg.enable && s.ir_sample > cfg.ir_presence_threshold) begin
         gap = s.time_ms - beat_time;
         if (gap > cfg.min_interval_ms && gap < cfg.max_interval_ms) begin
            hr = prse_pkg::MS_PER_MINUTE / gap;
            if (hr <= 255)
               rate_bpm = hr[RW-1:0];
            beat_time = s.time_ms;
            r.beat_accepted = 1'b1;
            if (s.red_sample > cfg.signal_floor && s.ir_sample > cfg.signal_floor) begin
               num = 64'(prse_pkg::SPO2_SLOPE) * s.red_sample;
               q = (num + s.ir_sample - 1) / s.ir_sample;
               if (q >= prse_pkg::SPO2_Q_LOW)
                  spo2_pct = prse_pkg::SPO2_MIN;
               else if (q <= prse_pkg::SPO2_Q_HIGH)
                  spo2_pct = prse_pkg::SPO2_MAX;
               else
                  spo2_pct = prse_pkg::SPO2_OFFSET - q[SW-1:0];
            end
         end else if (gap >= cfg.max_interval_ms) begin
            beat_time = s.time_ms;
         end
      end
      r.heart_rate_bpm = rate_bpm;
      r.spo2_percent = spo2_pct;
      return r;
   endfunction

   function automatic prse_pkg::req_type make_beat();
      prse_pkg::req_type s;
      int unsigned lo;
      int unsigned hi;
      int unsigned step;
      int unsigned red;
      int unsigned r;
      r = $urandom_range(99);
      lo = 32'(cfg.min_interval_ms);
      hi = 32'(cfg.max_interval_ms);
      s = '0;
      if (r < 60) begin
         case ($urandom_range(9))
            0:       step = lo;
            1:       step = lo + 1;
            2:       step = hi;
            3:       step = hi - 1;
            default: step = $urandom_range(lo, hi);
         endcase
         s.time_ms = beat_time + step;
      end else if (r < 80) begin
         s.time_ms = sample_clock + $urandom_range(0, 100);
      end else if (r < 90) begin
         s.time_ms = sample_clock + $urandom;
      end else begin
         s.time_ms = $urandom;
      end
      if (r >= 90 || cfg.ir_presence_threshold == SAMPLE_TOP || $urandom_range(9) == 0)
         s.ir_sample = FW'($urandom);
      else if ($urandom_range(1) == 0)
         s.ir_sample = FW'($urandom_range(cfg.ir_presence_threshold + 1,
                                          cfg.ir_presence_threshold + 2000 > SAMPLE_TOP ?
                                          SAMPLE_TOP : cfg.ir_presence_threshold + 2000));
      else
         s.ir_sample = FW'($urandom_range(cfg.ir_presence_threshold + 1, SAMPLE_TOP));
      if ($urandom_range(3) == 0) begin
         s.red_sample = FW'($urandom);
      end else begin
         red = (s.ir_sample * $urandom_range(20, 180)) / 100;
         s.red_sample = red > SAMPLE_TOP ? SAMPLE_TOP : FW'(red);
      end
      sample_clock = s.time_ms;
      return s;
   endfunction

   task automatic wait_drained();
      push <= 1'b0;
      while (readings_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [SEL_W-1:0] sel, input logic [DW-1:0] value);
      wait_drained();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= AW'({sel, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (sel)
         prse_pkg::CSR_ENABLE:       cfg.enable = value[0];
         prse_pkg::CSR_IR_THRESHOLD: cfg.ir_presence_threshold = value[FW-1:0];
         prse_pkg::CSR_MIN_INTERVAL: cfg.min_interval_ms = value[IW-1:0];
         prse_pkg::CSR_MAX_INTERVAL: cfg.max_interval_ms = value[IW-1:0];
         prse_pkg::CSR_SIGNAL_FLOOR: cfg.signal_floor = value[FW-1:0];
         default: ;
      endcase
   endtask

   task automatic send_sample(input prse_pkg::req_type s, input bit known,
                              input prse_pkg::rsp_type golden);
      prse_pkg::rsp_type due;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_item <= s;
      @(posedge clock);
      while (full)
         @(posedge clock);
      due = estimate_reading(s);
      readings_due.push_back(known ? golden : due);
   endtask

   task automatic add_sample(input int unsigned ir, input int unsigned red,
                             input logic [TW-1:0] t);
      plan_row_type row;
      row = '{ROW_SAMPLE, prse_pkg::CSR_ENABLE, '0, '{FW'(ir), FW'(red), t}, 1'b0, '0};
      plan.push_back(row);
   endtask

   task automatic add_known(input int unsigned ir, input int unsigned red,
                            input logic [TW-1:0] t, input int unsigned rate,
                            input int unsigned spo2, input bit acc);
      plan_row_type row;
      row = '{ROW_SAMPLE, prse_pkg::CSR_ENABLE, '0, '{FW'(ir), FW'(red), t}, 1'b1,
              '{RW'(rate), SW'(spo2), acc}};
      plan.push_back(row);
   endtask

   task automatic add_write(input logic [SEL_W-1:0] sel, input int unsigned value);
      plan_row_type row;
      row = '{ROW_WRITE, sel, DW'(value), '0, 1'b0, '0};
      plan.push_back(row);
   endtask

   task automatic pick_settings(input int phase);
      int unsigned lo;
      int unsigned hi;
      int unsigned thr;
      int unsigned flr;
      if (phase == 0) begin
         csr_write(prse_pkg::CSR_ENABLE, 1);
         csr_write(prse_pkg::CSR_IR_THRESHOLD, DW'(prse_pkg::RST_IR_THRESHOLD));
         csr_write(prse_pkg::CSR_MIN_INTERVAL, DW'(prse_pkg::RST_MIN_INTERVAL));
         csr_write(prse_pkg::CSR_MAX_INTERVAL, DW'(prse_pkg::RST_MAX_INTERVAL));
         csr_write(prse_pkg::CSR_SIGNAL_FLOOR, DW'(prse_pkg::RST_SIGNAL_FLOOR));
      end else begin
         case ($urandom_range(19))
            0:       lo = 0;
            1:       lo = 65535;
            default: lo = $urandom_range(0, 800);
         endcase
         case ($urandom_range(19))
            0:       hi = 1;
            1:       hi = 65535;
            default: hi = lo + $urandom_range(1, 3500) > 65535 ? 65535
                                                               : lo + $urandom_range(1, 3500);
         endcase
         case ($urandom_range(19))
            0:       thr = 0;
            1:       thr = SAMPLE_TOP;
            default: thr = $urandom_range(0, 120000);
         endcase
         case ($urandom_range(19))
            0:       flr = 0;
            1:       flr = SAMPLE_TOP;
            default: flr = $urandom_range(0, 20000);
         endcase
         csr_write(prse_pkg::CSR_ENABLE, DW'($urandom_range(9) != 0));
         csr_write(prse_pkg::CSR_IR_THRESHOLD, thr);
         csr_write(prse_pkg::CSR_MIN_INTERVAL, lo);
         csr_write(prse_pkg::CSR_MAX_INTERVAL, hi);
         csr_write(prse_pkg::CSR_SIGNAL_FLOOR, flr);
      end
   endtask

   // result side: check popped beats, random stalls, long hold-off on request
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (readings_due.size() == 0) begin
            $error("unexpected result beat: heart_rate_bpm %0d spo2_percent %0d",
                   rsp_item.heart_rate_bpm, rsp_item.spo2_percent);
            fail_count++;
         end else begin
            oldest_due = readings_due.pop_front();
            if (rsp_item.heart_rate_bpm !== oldest_due.heart_rate_bpm) begin
               $error("heart_rate_bpm: expected %0d, actual %0d",
                      oldest_due.heart_rate_bpm, rsp_item.heart_rate_bpm);
               fail_count++;
            end
            if (rsp_item.spo2_percent !== oldest_due.spo2_percent) begin
               $error("spo2_percent: expected %0d, actual %0d",
                      oldest_due.spo2_percent, rsp_item.spo2_percent);
               fail_count++;
            end
            if (rsp_item.beat_accepted !== oldest_due.beat_accepted) begin
               $error("beat_accepted: expected %0d, actual %0d",
                      oldest_due.beat_accepted, rsp_item.beat_accepted);
               fail_count++;
            end
         end
      end
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      plan_row_type row;
      cfg = '{1'b1, prse_pkg::RST_IR_THRESHOLD, prse_pkg::RST_MIN_INTERVAL,
              prse_pkg::RST_MAX_INTERVAL, prse_pkg::RST_SIGNAL_FLOOR};
      beat_time = '0;
      rate_bpm = '0;
      spo2_pct = '0;

      // not present, at threshold, first beat, gap at minimum
      add_known(0, 0, 32'd0, 0, 0, 0);
      add_known(50000, 0, 32'd1000, 0, 0, 0);
      add_known(262143, 262143, 32'd500, 120, 85, 1);
      add_known(262143, 0, 32'd800, 120, 85, 0);
      add_sample(262143, 0, 32'd801);
      // gap at maximum re-arms, then just below
      add_known(100000, 5000, 32'd3801, 199, 85, 0);
      add_sample(262143, 262143, 32'd6800);
      // SpO2 clamps and signal floor
      add_known(262143, 1001, 32'd7400, 100, 100, 1);
      add_known(60000, 262143, 32'd8000, 100, 70, 1);
      add_sample(262143, 1000, 32'd8600);
      // timestamp wrap
      add_sample(262143, 0, 32'hFFFF_FF00);
      add_sample(100000, 100000, 32'h0000_0100);
      add_write(prse_pkg::CSR_ENABLE, 0);
      add_known(262143, 262143, 32'h0000_0200, 117, 85, 0);
      add_write(prse_pkg::CSR_ENABLE, 1);
      add_write(prse_pkg::CSR_MIN_INTERVAL, 0);
      add_write(prse_pkg::CSR_MAX_INTERVAL, 65535);
      // rate too large, then the 8-bit edge
      add_sample(200000, 200000, 32'h0000_0101);
      add_sample(200000, 200000, 32'h0000_01EC);
      add_sample(200000, 200000, 32'h0000_02D8);
      // minimum equal to maximum, maximum of one
      add_write(prse_pkg::CSR_MIN_INTERVAL, 500);
      add_write(prse_pkg::CSR_MAX_INTERVAL, 500);
      add_known(262143, 262143, 32'h0000_04CC, 254, 85, 0);
      add_write(prse_pkg::CSR_MIN_INTERVAL, 0);
      add_write(prse_pkg::CSR_MAX_INTERVAL, 1);
      add_known(262143, 262143, 32'h0000_04CD, 254, 85, 0);
      // threshold and floor extremes
      add_write(prse_pkg::CSR_MAX_INTERVAL, 65535);
      add_write(prse_pkg::CSR_IR_THRESHOLD, 262143);
      add_known(262143, 262143, 32'h0000_1000, 254, 85, 0);
      add_write(prse_pkg::CSR_IR_THRESHOLD, 0);
      add_write(prse_pkg::CSR_SIGNAL_FLOOR, 0);
      add_sample(1, 1, 32'h0000_EF2D);
      add_write(prse_pkg::CSR_SIGNAL_FLOOR, 262143);
      add_sample(262143, 262143, 32'h0000_F315);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_WRITE)
            csr_write(row.sel, row.wdata);
         else
            send_sample(row.sample, row.known, row.golden);
      end
      sample_clock = beat_time;

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         pick_settings(phase);
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 54;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 54;
            end
            default: begin
               send_idle_pct = 22;
               stall_pct <= 22;
            end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (n == 50 && phase % 4 == 0)
               hold_requests <= hold_requests + 1;
            if (n == 150)
               wait_drained();
            send_sample(make_beat(), 1'b0, '0);
         end
      end

      wait_drained();
      if (fail_count == 0)
         $display("** pulse_rate_and_spo2_estimator: PASSED **");
      else
         $display("** pulse_rate_and_spo2_estimator: FAILED **");
      $finish;
   end

endmodule
